[rtl/display_list_command_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the display-list command sequencer
// Concurrent assertion wrappers; empty bodies when synthesising.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_LIST_COMMAND_SEQUENCER_MACROS_SVH
`define DISPLAY_LIST_COMMAND_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define DLCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DLCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DLCS_ASSERT_IMPL(lbl, ante, cons)
`define DLCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/dlcs_pkg.sv]
// ----------------------------------------------------------------------------
// dlcs_pkg
// Shared types and constants of the display-list command sequencer.
// ----------------------------------------------------------------------------
package dlcs_pkg;
  localparam int STACK_DEPTH    = 8;
  localparam int SEGMENTS       = 16;
  localparam int VERTEX_LIMIT   = 80;
  localparam int TRIANGLE_BATCH = 80;
  localparam int VIEW_STACK_MAX = 9;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int SEG_W = $clog2(SEGMENTS);

  localparam logic [7:0] OP_VTX    = 8'h01;
  localparam logic [7:0] OP_TRI1   = 8'h05;
  localparam logic [7:0] OP_TRI2   = 8'h06;
  localparam logic [7:0] OP_QUAD   = 8'h07;
  localparam logic [7:0] OP_POPMTX = 8'hD8;
  localparam logic [7:0] OP_GEOM   = 8'hD9;
  localparam logic [7:0] OP_MTX    = 8'hDA;
  localparam logic [7:0] OP_MOVEW  = 8'hDB;
  localparam logic [7:0] OP_DL     = 8'hDE;
  localparam logic [7:0] OP_ENDDL  = 8'hDF;
  localparam logic [7:0] OP_OML    = 8'hE2;
  localparam logic [7:0] OP_OMH    = 8'hE3;
  localparam logic [7:0] OP_RDP    = 8'hC0;
  localparam logic [7:0] OP_NOFWD  = 8'hF1;
  localparam logic [7:0] OP_FWDLO  = 8'hE4;
  localparam logic [7:0] MW_SEGMENT = 8'h06;

  typedef enum logic [2:0] {
    K_ADVANCE = 3'd0, K_TRI = 3'd1, K_FLUSH = 3'd2, K_VTX = 3'd3,
    K_MTX = 3'd4, K_FWD = 3'd5, K_HALT = 3'd6
  } kind_t;

  // one command (two raw words) passed from front to back
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] fetch;
    logic [31:0] target;
    logic [31:0] a;
    logic [31:0] b;
    logic [6:0]  c;
    logic [31:0] geom;
    logic [31:0] omh;
    logic [31:0] oml;
    logic        running;
    logic        last;
  } res_t;

  localparam int RES_W = $bits(res_t);
endpackage

[rtl/dlcs_front.sv]
// ----------------------------------------------------------------------------
// dlcs_front
// Two-entry input command queue.
// ----------------------------------------------------------------------------
module dlcs_front import dlcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cmd_t        in_cmd,
  output logic        q_valid,
  input  logic        q_take,
  output cmd_t        q_cmd
);
  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[0];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // take and push together only with one entry held: the new item becomes the head
  always_ff @(posedge clk) begin
    if (q_take) begin
      if (push) q_r[0] <= in_cmd;
      else q_r[0] <= q_r[1];
    end else if (push) begin
      if (cnt_r == 2'd0) q_r[0] <= in_cmd;
      else q_r[1] <= in_cmd;
    end
  end
endmodule

[rtl/dlcs_back.sv]
// ----------------------------------------------------------------------------
// dlcs_back
// Execution unit: holds the sequencer state, runs one command and emits
// its results into an output register, one per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
module dlcs_back import dlcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic [31:0] list_start,
  input  logic        q_valid,
  output logic        q_take,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);
  logic [31:0] pc_r [STACK_DEPTH];
  logic [SP_W-1:0] sp_r;
  logic [23:0] seg_r [SEGMENTS];
  logic [31:0] geom_r, omh_r, oml_r, ls_r;
  logic [3:0]  vd_r;
  logic [6:0]  pend_r;
  logic        halt_r;

  // result list of the command being executed
  res_t        res_r [4];
  logic [2:0]  nres_r, idx_r;
  logic        busy_r;
  logic        ov_r;
  res_t        ob_r;
  res_t        ob_nxt;

  logic [31:0] w0, w1;
  logic [7:0]  op;
  logic        tri_c;
  res_t        r_n [4];
  logic [2:0]  n_n;
  logic [6:0]  pend_n;
  logic [31:0] geom_n, omh_n, oml_n, top_n, push_n, addr, mask;
  logic [SP_W-1:0] sp_n;
  logic [3:0]  vd_n;
  logic        halt_n, wr_top, wr_push;
  logic [7:0]  num, v0;
  logic [8:0]  len, sh;
  logic [31:0] base;
  logic [7:0]  flags;
  logic        start, emit_ok;
  logic [SEG_W-1:0] seg_w;
  logic        seg_we;

  assign list_start = ls_r;
  assign w0 = q_cmd.w0;
  assign w1 = q_cmd.w1;
  assign op = w0[31:24];
  assign tri_c = (op == OP_TRI1) || (op == OP_TRI2) || (op == OP_QUAD);
  assign addr = {8'd0, seg_r[w1[27:24]]} + {9'd0, w1[22:0]};
  assign emit_ok = !ov_r || out_ready;
  // a register write holds off the next command for that cycle
  assign start = q_valid && !busy_r && !cfg_we;
  assign q_take = start;

  always_comb begin
    len  = {1'b0, w0[7:0]} + 9'd1;
    sh   = (9'd32 - {1'b0, w0[15:8]} - len) & 9'h0FF;
    base = (len >= 9'd32) ? 32'hFFFF_FFFF : ((32'd1 << len[4:0]) - 32'd1);
    mask = (sh >= 9'd32) ? 32'd0 : (base << sh[4:0]);
  end

  always_comb begin
    res_t t;
    logic [6:0] p;
    t = '0;
    for (int k = 0; k < 4; k++) r_n[k] = '0;
    n_n = 3'd0;
    p = pend_r;
    geom_n = geom_r; omh_n = omh_r; oml_n = oml_r;
    sp_n = sp_r; vd_n = vd_r; halt_n = halt_r;
    top_n = pc_r[sp_r] + 32'd8; wr_top = 1'b0;
    push_n = addr; wr_push = 1'b0;
    seg_we = 1'b0; seg_w = w0[5:2];
    num = w0[19:12];
    v0 = {1'b0, w0[7:1]} - num;
    flags = w0[7:0] ^ 8'd1;
    if (halt_r) begin
      r_n[0].kind = K_HALT; n_n = 3'd1;
    end else begin
      wr_top = 1'b1;
      if (!tri_c && p != 7'd0) begin
        r_n[0].kind = K_FLUSH; n_n = 3'd1; p = 7'd0;
      end
      if (tri_c) begin
        for (int j = 0; j < 2; j++) begin
          if (j == 0 || op != OP_TRI1) begin
            t = '0; t.kind = K_TRI;
            t.a = {25'd0, (j == 0 ? w0[23:17] : w1[23:17])};
            t.b = {25'd0, (j == 0 ? w0[15:9] : w1[15:9])};
            t.c = (j == 0 ? w0[7:1] : w1[7:1]);
            r_n[n_n[1:0]] = t; n_n = n_n + 3'd1;
            p = p + 7'd1;
            if (p >= 7'(TRIANGLE_BATCH)) begin
              t = '0; t.kind = K_FLUSH;
              r_n[n_n[1:0]] = t; n_n = n_n + 3'd1; p = 7'd0;
            end
          end
        end
      end else begin
        t = '0; t.kind = K_ADVANCE;
        unique case (op)
          OP_VTX: if ({1'b0, v0} + {1'b0, num} <= 9'(VERTEX_LIMIT)) begin
            t.kind = K_VTX; t.target = addr; t.a = {24'd0, v0}; t.b = {24'd0, num};
          end
          OP_POPMTX: if (vd_r != 4'd0) vd_n = vd_r - 4'd1;
          OP_GEOM: geom_n = (geom_r & {8'd0, w0[23:0]}) | w1;
          OP_MTX: begin
            if (!flags[2] && flags[0] && vd_r < 4'(VIEW_STACK_MAX)) vd_n = vd_r + 4'd1;
            t.kind = K_MTX; t.target = addr; t.a = {24'd0, flags};
          end
          OP_MOVEW: seg_we = (w0[23:16] == MW_SEGMENT);
          OP_DL: begin
            wr_top = 1'b0;
            if (w0[23:16] == 8'd0) begin
              if (sp_r != SP_W'(STACK_DEPTH - 1)) begin
                wr_top = 1'b1; wr_push = 1'b1; sp_n = sp_r + 1'b1;
              end else begin
                halt_n = 1'b1; t.kind = K_HALT;
              end
            end else begin
              wr_top = 1'b1; top_n = addr;
            end
          end
          OP_ENDDL: begin
            wr_top = 1'b0;
            if (sp_r != '0) sp_n = sp_r - 1'b1;
            else begin halt_n = 1'b1; t.kind = K_HALT; end
          end
          OP_OML: oml_n = (oml_r & ~mask) | (w1 & mask);
          OP_OMH: omh_n = (omh_r & ~mask) | (w1 & mask);
          default: if (op == OP_RDP || (op >= OP_FWDLO && op != OP_NOFWD)) begin
            t.kind = K_FWD; t.a = w0; t.b = w1;
          end
        endcase
        r_n[n_n[1:0]] = t; n_n = n_n + 3'd1;
      end
    end
    pend_n = p;
  end

  // result item with the state after the command filled in
  always_comb begin
    ob_nxt = res_r[idx_r[1:0]];
    ob_nxt.fetch = pc_r[sp_r];
    ob_nxt.geom = geom_r; ob_nxt.omh = omh_r; ob_nxt.oml = oml_r;
    ob_nxt.running = !halt_r;
    ob_nxt.last = (idx_r + 3'd1 == nres_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0; geom_r <= '0; omh_r <= '0; oml_r <= '0; ls_r <= '0;
      vd_r <= '0; pend_r <= '0; halt_r <= 1'b0;
      busy_r <= 1'b0; ov_r <= 1'b0; idx_r <= '0; nres_r <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) pc_r[i] <= '0;
      for (int i = 0; i < SEGMENTS; i++) seg_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        ls_r <= cfg_data; pc_r[0] <= cfg_data; sp_r <= '0; halt_r <= 1'b0;
      end else if (start) begin
        pend_r <= pend_n; geom_r <= geom_n; omh_r <= omh_n; oml_r <= oml_n;
        sp_r <= sp_n; vd_r <= vd_n; halt_r <= halt_n;
        if (wr_top) pc_r[sp_r] <= top_n;
        if (wr_push) pc_r[sp_n] <= push_n;
        if (seg_we) seg_r[seg_w] <= w1[23:0];
        for (int k = 0; k < 4; k++) res_r[k] <= r_n[k];
        nres_r <= n_n; idx_r <= '0; busy_r <= 1'b1;
      end
      if (busy_r && emit_ok) begin
        ov_r <= 1'b1;
        idx_r <= idx_r + 3'd1;
        if (idx_r + 3'd1 == nres_r) busy_r <= 1'b0;
      end else if (out_valid && out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && emit_ok) begin
      ob_r <= ob_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_res   = ob_r;
endmodule

[rtl/display_list_command_sequencer.sv]
// ----------------------------------------------------------------------------
// display_list_command_sequencer
// Display-list command sequencer top level.
// ----------------------------------------------------------------------------
// Each item is one 64-bit command (word0 low, word1 high). A two-entry queue
// takes items while the execution unit works; the unit reads a command,
// updates the PC stack and mode state, then emits its one to four results
// one per cycle, unless the receiver stalls, through an output register.
// The unit takes no new command until every result of the last one is out;
// its execution loop runs the state update, then the result drain.
// The result kind travels on out_tuser and the final result of a command
// is marked by out_tlast.
// list_start is written at address 0 of the configuration port and reloads
// PC stack entry zero, clears the stack index and leaves halt.
// ----------------------------------------------------------------------------
`include "display_list_command_sequencer_macros.svh"
module display_list_command_sequencer import dlcs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // cmd_word0, cmd_word1
  output logic         out_tvalid,
  input  logic         out_tready,
  // fetch_address, target_address, arg_a, arg_b, arg_c,
  // geometry_mode, other_mode_high, other_mode_low, running
  output logic [231:0] out_tdata,
  output logic [2:0]   out_tuser,  // result_kind
  output logic         out_tlast,  // last
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic         cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  cmd_t  in_cmd, q_cmd;
  logic  q_valid, q_take, cfg_we;
  logic [31:0] ls;
  res_t  res;

  assign in_cmd.w0 = in_tdata[31:0];
  assign in_cmd.w1 = in_tdata[63:32];
  assign cfg_pready = 1'b1;
  // only register 0 exists; other addresses are ignored
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 1'b0);
  assign cfg_prdata = (cfg_paddr == 1'b0) ? ls : 32'd0;

  dlcs_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .q_valid, .q_take, .q_cmd
  );

  dlcs_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_data(cfg_pwdata), .list_start(ls),
    .q_valid, .q_take, .q_cmd, .out_valid(out_tvalid), .out_ready(out_tready),
    .out_res(res)
  );

  assign out_tdata = {res.running, res.oml, res.omh, res.geom,
                      res.c, res.b, res.a, res.target, res.fetch};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  `DLCS_ASSERT_IMPL(a_halt_not_running, out_tvalid && res.kind == K_HALT, !res.running)
  `DLCS_ASSERT_IMPL(a_kind_range, out_tvalid, res.kind != 3'd7)
  `DLCS_ASSERT_NEXT(a_cfg_clears, cfg_we, ls == $past(cfg_pwdata))
endmodule

[tb/tb_display_list_command_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Display-list command sequencer testbench
// Drives commands over the input stream, predicts every result from an
// in-bench copy of the PC stack, segment table and mode words, and checks
// each output item field by field. Reloads list_start between phases.
// ----------------------------------------------------------------------------
module tb_display_list_command_sequencer;
  import dlcs_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;    // cmd_word0, cmd_word1
  logic         out_tvalid;
  logic         out_tready;
  // fetch_address, target_address, arg_a, arg_b, arg_c,
  // geometry_mode, other_mode_high, other_mode_low, running
  logic [231:0] out_tdata;
  logic [2:0]   out_tuser;   // result_kind
  logic         out_tlast;   // last
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic         cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  display_list_command_sequencer u_top (.*);

  localparam logic [7:0] OP_FWDHI = 8'hFF;

  // directed rows; chk_kind says the final result kind is typed in
  typedef struct {
    logic [31:0] w0;
    logic [31:0] w1;
    bit          chk_kind;
    kind_t       kind;
  } cmd_row_t;

  // predicted sequencer state
  logic [31:0] pc_q [STACK_DEPTH];
  int unsigned sp_q;
  logic [23:0] seg_q [SEGMENTS];
  logic [31:0] geom_q, omh_q, oml_q;
  int unsigned view_q, tri_pend_q;
  bit          halt_q;

  res_t        pending_res[$];   // expected output items, oldest first
  res_t        cmd_res[$];       // results of the command being predicted
  int          mismatches;
  bit          calm;             // no idling on either side
  bit          hold_req;
  int          hold_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] seg_addr(logic [31:0] w);
    return {8'h00, seg_q[w[27:24]]} + {9'h000, w[22:0]};
  endfunction

  function automatic void put_res(kind_t k, logic [31:0] t, logic [31:0] a,
                                  logic [31:0] b, logic [6:0] c);
    res_t r;
    r = '0;
    r.kind = k; r.target = t; r.a = a; r.b = b; r.c = c;
    cmd_res.push_back(r);
  endfunction

  function automatic void tri_item(logic [31:0] w);
    put_res(K_TRI, '0, {25'h0, w[23:17]}, {25'h0, w[15:9]}, w[7:1]);
    tri_pend_q = (tri_pend_q + 1) & 8'h7F;
    if (tri_pend_q >= TRIANGLE_BATCH) begin
      put_res(K_FLUSH, '0, '0, '0, '0);
      tri_pend_q = 0;
    end
  endfunction

  // other-mode field mask: length from bits 7..0, shift from bits 15..8
  function automatic logic [31:0] om_mask(logic [31:0] w0);
    int unsigned len, sh;
    logic [31:0] ones;
    len = w0[7:0] + 1;
    sh = (32 - w0[15:8] - len) & 8'hFF;
    ones = (len >= 32) ? 32'hFFFF_FFFF : ((32'h1 << len) - 1);
    if (sh >= 32) return '0;
    return ones << sh;
  endfunction

  function automatic void list_start_load(logic [31:0] v);
    pc_q[0] = v;
    sp_q = 0;
    halt_q = 1'b0;
  endfunction

  // executes one command on the predicted state, queues its results
  function automatic void exec_cmd(logic [31:0] w0, logic [31:0] w1);
    logic [7:0]  op;
    logic [31:0] m, fl;
    int unsigned num, v0;
    bit          is_tri, adv;
    op = w0[31:24];
    is_tri = (op == OP_TRI1 || op == OP_TRI2 || op == OP_QUAD);
    adv = 1'b1;
    cmd_res.delete();
    if (halt_q) begin
      put_res(K_HALT, '0, '0, '0, '0);
      adv = 1'b0;
    end else begin
      // leaving a triangle run flushes the batch first
      if (!is_tri && tri_pend_q != 0) begin
        put_res(K_FLUSH, '0, '0, '0, '0);
        tri_pend_q = 0;
      end
      if (is_tri) begin
        tri_item(w0);
        if (op != OP_TRI1) tri_item(w1);
      end else if (op == OP_VTX) begin
        num = w0[19:12];
        v0 = (w0[7:1] - num) & 8'hFF;
        if (v0 + num > VERTEX_LIMIT) put_res(K_ADVANCE, '0, '0, '0, '0);
        else put_res(K_VTX, seg_addr(w1), v0, num, '0);
      end else if (op == OP_POPMTX) begin
        if (view_q > 0) view_q--;
        put_res(K_ADVANCE, '0, '0, '0, '0);
      end else if (op == OP_GEOM) begin
        geom_q = (geom_q & {8'h00, w0[23:0]}) | w1;
        put_res(K_ADVANCE, '0, '0, '0, '0);
      end else if (op == OP_MTX) begin
        fl = {24'h0, w0[7:0] ^ 8'h01};
        if (!fl[2] && fl[0] && view_q < VIEW_STACK_MAX) view_q++;
        put_res(K_MTX, seg_addr(w1), fl, '0, '0);
      end else if (op == OP_MOVEW) begin
        if (w0[23:16] == MW_SEGMENT) seg_q[w0[5:2]] = w1[23:0];
        put_res(K_ADVANCE, '0, '0, '0, '0);
      end else if (op == OP_DL) begin
        adv = 1'b0;
        if (w0[23:16] == 8'h00) begin
          if (sp_q < STACK_DEPTH - 1) begin
            pc_q[sp_q] += 8;
            sp_q++;
            pc_q[sp_q] = seg_addr(w1);
            put_res(K_ADVANCE, '0, '0, '0, '0);
          end else begin
            // call overflow: halt, PC kept
            halt_q = 1'b1;
            put_res(K_HALT, '0, '0, '0, '0);
          end
        end else begin
          pc_q[sp_q] = seg_addr(w1);
          put_res(K_ADVANCE, '0, '0, '0, '0);
        end
      end else if (op == OP_ENDDL) begin
        adv = 1'b0;
        if (sp_q > 0) begin
          sp_q--;
          put_res(K_ADVANCE, '0, '0, '0, '0);
        end else begin
          halt_q = 1'b1;
          put_res(K_HALT, '0, '0, '0, '0);
        end
      end else if (op == OP_OML || op == OP_OMH) begin
        m = om_mask(w0);
        if (op == OP_OML) oml_q = (oml_q & ~m) | (w1 & m);
        else omh_q = (omh_q & ~m) | (w1 & m);
        put_res(K_ADVANCE, '0, '0, '0, '0);
      end else if (op == OP_RDP || (op >= OP_FWDLO && op != OP_NOFWD)) begin
        put_res(K_FWD, '0, w0, w1, '0);
      end else begin
        put_res(K_ADVANCE, '0, '0, '0, '0);
      end
      if (adv) pc_q[sp_q] += 8;
    end
    foreach (cmd_res[i]) begin
      cmd_res[i].fetch   = pc_q[sp_q];
      cmd_res[i].geom    = geom_q;
      cmd_res[i].omh     = omh_q;
      cmd_res[i].oml     = oml_q;
      cmd_res[i].running = !halt_q;
      cmd_res[i].last    = (i == cmd_res.size() - 1);
    end
  endfunction

  // offers one item; predicts it once accepted
  task automatic send_cmd(logic [31:0] w0, logic [31:0] w1, bit chk, kind_t k);
    if (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w1, w0};
    do @(posedge clk); while (!in_tready);
    exec_cmd(w0, w1);
    if (chk) cmd_res[cmd_res.size() - 1].kind = k;
    foreach (cmd_res[i]) pending_res.push_back(cmd_res[i]);
  endtask

  task automatic drain_wait();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_list_start(logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 1'b0;
    cfg_pwdata  <= v;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    list_start_load(v);
  endtask

  // random command, weighted towards well-formed list traffic
  task automatic rand_cmd(bit tri_burst);
    logic [31:0] w0, w1;
    int unsigned p;
    w0 = $urandom;
    w1 = $urandom;
    p = tri_burst ? 0 : $urandom_range(99);
    if (p < 12)       w0[31:24] = OP_QUAD;
    else if (p < 18)  w0[31:24] = OP_TRI1;
    else if (p < 22)  w0[31:24] = OP_TRI2;
    else if (p < 32) begin
      w0[31:24] = OP_VTX;
      if ($urandom_range(1)) w0[19:12] = 8'($urandom_range(40));
    end
    else if (p < 36)  w0[31:24] = OP_POPMTX;
    else if (p < 41)  w0[31:24] = OP_GEOM;
    else if (p < 47)  w0[31:24] = OP_MTX;
    else if (p < 55) begin
      w0[31:24] = OP_MOVEW;
      if ($urandom_range(3) != 0) w0[23:16] = MW_SEGMENT;
    end
    else if (p < 65) begin
      w0[31:24] = OP_DL;
      if ($urandom_range(2) != 0) w0[23:16] = 8'h00;
    end
    else if (p < 69)  w0[31:24] = OP_ENDDL;
    else if (p < 75)  w0[31:24] = OP_OML;
    else if (p < 81)  w0[31:24] = OP_OMH;
    else if (p < 84)  w0[31:24] = OP_RDP;
    else if (p < 88)  w0[31:24] = OP_NOFWD;
    else if (p < 94)  w0[31:24] = 8'($urandom_range(OP_FWDHI, OP_FWDLO));
    send_cmd(w0, w1, 1'b0, K_ADVANCE);
  endtask

  // receiver: random back-pressure, one long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req   = 1'b0;
      hold_cnt   = 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got         = '0;
      got.kind    = kind_t'(out_tuser);
      got.fetch   = out_tdata[31:0];
      got.target  = out_tdata[63:32];
      got.a       = out_tdata[95:64];
      got.b       = out_tdata[127:96];
      got.c       = out_tdata[134:128];
      got.geom    = out_tdata[166:135];
      got.omh     = out_tdata[198:167];
      got.oml     = out_tdata[230:199];
      got.running = out_tdata[231];
      got.last    = out_tlast;
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  cmd_row_t rows[$];

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = 1'b0; cfg_pwdata = '0;
    mismatches = 0; calm = 1'b0; hold_req = 1'b0; hold_cnt = 0;
    foreach (pc_q[i]) pc_q[i] = '0;
    foreach (seg_q[i]) seg_q[i] = '0;
    sp_q = 0; geom_q = '0; omh_q = '0; oml_q = '0;
    view_q = 0; tri_pend_q = 0; halt_q = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each opcode class, flush and halt cases
    rows = '{
      '{32'hF1FF_FFFF, 32'h0000_0000, 1, K_ADVANCE},
      '{32'hDB06_0004, 32'hFFFF_FFFF, 1, K_ADVANCE},   // segment 1 at max
      '{32'h0101_0020, 32'h01FF_FFFF, 1, K_VTX},
      '{32'h01FF_F0FE, 32'h0000_0000, 1, K_ADVANCE},   // over vertex limit
      '{32'h05FE_FEFE, 32'h0000_0000, 1, K_TRI},
      '{32'h0600_0000, 32'hFFFF_FFFF, 1, K_TRI},
      '{32'h07AA_5555, 32'h0055_AAAA, 1, K_TRI},
      '{32'hD900_0000, 32'hFFFF_FFFF, 1, K_ADVANCE},   // flush then advance
      '{32'hD9FF_FFFF, 32'h0000_0000, 1, K_ADVANCE},
      '{32'hDA00_0000, 32'h01FF_FFFF, 1, K_MTX},
      '{32'hDA00_00FF, 32'h0000_0000, 1, K_MTX},
      '{32'hD800_0000, 32'h0000_0000, 1, K_ADVANCE},
      '{32'hE200_001F, 32'hFFFF_FFFF, 1, K_ADVANCE},   // length 32: all ones
      '{32'hE300_2000, 32'hFFFF_FFFF, 1, K_ADVANCE},   // shift out of range
      '{32'hE300_0807, 32'hA5A5_A5A5, 1, K_ADVANCE},
      '{32'hC000_0000, 32'hFFFF_FFFF, 1, K_FWD},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1, K_FWD},
      '{32'hE400_0000, 32'h1234_5678, 1, K_FWD},
      '{32'hDE00_0000, 32'h0100_0100, 1, K_ADVANCE},   // call
      '{32'hDE01_0000, 32'h0000_0200, 1, K_ADVANCE},   // branch
      '{32'hDF00_0000, 32'h0000_0000, 1, K_ADVANCE},   // return
      '{32'hDF00_0000, 32'h0000_0000, 1, K_HALT},      // end at top
      '{32'h0500_0000, 32'h0000_0000, 1, K_HALT}       // halted
    };
    foreach (rows[i]) send_cmd(rows[i].w0, rows[i].w1, rows[i].chk_kind, rows[i].kind);
    drain_wait();

    // random phases, list_start reloaded between them
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       write_list_start(32'hFFFF_FFFF);
        1:       write_list_start(32'h0000_0000);
        2:       write_list_start(32'hFFFF_FFF8);
        default: write_list_start($urandom);
      endcase
      calm = (ph == 6 || ph == 7);
      for (int n = 0; n < 37; n++) begin
        if (ph == 4 && n == 5) hold_req = 1'b1;   // long receiver hold
        rand_cmd(ph == 3);                        // triangle burst fills a batch
      end
      if (ph == 3) for (int n = 0; n < 5; n++) rand_cmd(1'b1);
      drain_wait();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
